### hdl/atan2ba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan2ba_pkg
// Shared types and constants for the binary-angle atan2 CORDIC pipeline.
// ----------------------------------------------------------------------------
package atan2ba_pkg;

	localparam int STEPS   = 30;   // CORDIC iterations, one per stage
	localparam int XY_W    = 62;   // x/y datapath, magnitude stays below 2^60
	localparam int Z_W     = 32;   // angle accumulator, 2^-32 turn units
	localparam int ANGLE_W = 16;   // result, 65536 units per turn
	localparam int MAG_LSB = 59;   // full-scale coordinate lands at 2^58

	localparam logic [Z_W-1:0] HALF_TURN_Z = 32'h8000_0000;
	localparam logic [Z_W-1:0] ROUND_HALF  = 32'h0000_8000;

	// atan(2^-i) / (2*pi) * 2^32, truncated
	localparam logic [Z_W-1:0] STEP_ANGLE [0:STEPS-1] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
	};

	// Payload carried between pipeline stages
	typedef struct packed {
		logic                   zero;   // both coordinates zero
		logic                   half;   // reference axis was negative
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} stage_t;

endpackage

### hdl/atan2ba_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan2ba_prep
// Input stage: half-turn fold of the left half plane and prescale to the
// CORDIC datapath.
// ----------------------------------------------------------------------------
module atan2ba_prep #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic signed [COORD_BITS-1:0] ref_axis,
	input  logic signed [COORD_BITS-1:0] quarter_axis,
	output logic                         out_valid,
	output atan2ba_pkg::stage_t          out_stage
);

	localparam int PRE_SHIFT = atan2ba_pkg::MAG_LSB - COORD_BITS;

	logic                                    neg;
	logic signed [COORD_BITS:0]              rx_e, qy_e, rx_f, qy_f;
	logic signed [atan2ba_pkg::XY_W-1:0]     x_ext, y_ext;
	logic                                    valid_s1;
	atan2ba_pkg::stage_t                     stage_s1;

	always_comb begin
		rx_e  = (COORD_BITS+1)'(ref_axis);
		qy_e  = (COORD_BITS+1)'(quarter_axis);
		neg   = ref_axis[COORD_BITS-1];
		// one extra bit so the most negative value negates cleanly
		rx_f  = neg ? -rx_e : rx_e;
		qy_f  = neg ? -qy_e : qy_e;
		x_ext = atan2ba_pkg::XY_W'(rx_f);
		y_ext = atan2ba_pkg::XY_W'(qy_f);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			stage_s1.zero <= (ref_axis == '0) && (quarter_axis == '0);
			stage_s1.half <= neg;
			stage_s1.x    <= x_ext <<< PRE_SHIFT;
			stage_s1.y    <= y_ext <<< PRE_SHIFT;
			stage_s1.z    <= '0;
		end
	end

	assign out_valid = valid_s1;
	assign out_stage = stage_s1;

endmodule

### hdl/atan2ba_cordic_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan2ba_cordic_stage
// One registered CORDIC vectoring iteration, rotating y toward zero.
// ----------------------------------------------------------------------------
module atan2ba_cordic_stage #(
	parameter int STEP = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  atan2ba_pkg::stage_t in_stage,
	output logic                out_valid,
	output atan2ba_pkg::stage_t out_stage
);

	logic signed [atan2ba_pkg::XY_W-1:0] x_in, y_in, dx, dy;
	logic                                pos;
	logic                                valid_q;
	atan2ba_pkg::stage_t                 nxt, stage_q;

	always_comb begin
		x_in = in_stage.x;
		y_in = in_stage.y;
		dx   = y_in >>> STEP;   // arithmetic shift floors
		dy   = x_in >>> STEP;
		pos  = !y_in[atan2ba_pkg::XY_W-1] && (y_in != '0);
		nxt  = in_stage;
		if (pos) begin
			nxt.x = x_in + dx;
			nxt.y = y_in - dy;
			nxt.z = in_stage.z + $signed(atan2ba_pkg::STEP_ANGLE[STEP]);
		end else begin
			nxt.x = x_in - dx;
			nxt.y = y_in + dy;
			nxt.z = in_stage.z - $signed(atan2ba_pkg::STEP_ANGLE[STEP]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			stage_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_stage = stage_q;

endmodule

### hdl/atan2ba_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan2ba_round
// Output stage: half-turn offset, round to nearest unit, zero-vector case.
// ----------------------------------------------------------------------------
module atan2ba_round (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  atan2ba_pkg::stage_t               in_stage,
	output logic                              done,
	output logic [atan2ba_pkg::ANGLE_W-1:0]   angle
);

	logic [atan2ba_pkg::Z_W-1:0]     total;
	logic                            done_q;
	logic [atan2ba_pkg::ANGLE_W-1:0] angle_q;

	always_comb begin
		total = (in_stage.half ? atan2ba_pkg::HALF_TURN_Z : '0)
		      + atan2ba_pkg::Z_W'(in_stage.z) + atan2ba_pkg::ROUND_HALF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			angle_q <= in_stage.zero ? '0
			         : total[atan2ba_pkg::Z_W-1 -: atan2ba_pkg::ANGLE_W];
		end
	end

	assign done  = done_q;
	assign angle = angle_q;

endmodule

### hdl/atan2_binary_angle_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan2_binary_angle_top
// Direction of a coordinate pair as a 16-bit binary angle, CORDIC pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Drive ref_axis / quarter_axis and pulse start. A transfer happens on the
//   rising edge where start is high and busy is low. busy is always low: the
//   pipeline takes a new coordinate pair every cycle.
//   Each transfer yields one angle = atan2(quarter_axis, ref_axis) in units
//   of 1/65536 turn, rounded to nearest. A zero vector gives 0.
//   The result appears on angle with done high for exactly one cycle. The
//   input stage (half-turn fold and prescale) registers at the transfer
//   edge, then 30 CORDIC stages (one iteration each) and one rounding
//   stage follow, each registered in turn.
//   Throughput is one item per cycle; results leave in input order.
//   The receiver cannot stall: it must take angle in the cycle done is high.
//   Reset (arst_n low, asynchronous) clears all valid bits; items in flight
//   are dropped and done stays low until new transfers come through.
// ----------------------------------------------------------------------------
module atan2_binary_angle_top #(
	parameter int COORD_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [COORD_BITS-1:0]         ref_axis,
	input  logic signed [COORD_BITS-1:0]         quarter_axis,
	output logic                                 done,
	output logic [atan2ba_pkg::ANGLE_W-1:0]      angle
);

	// stage 0 is the prepped input; stage g+1 follows CORDIC iteration g
	logic                valid_s [0:atan2ba_pkg::STEPS];
	atan2ba_pkg::stage_t data_s  [0:atan2ba_pkg::STEPS];
	logic                take;

	// fully pipelined, never refuses a transfer
	assign busy = 1'b0;
	assign take = start && !busy;

	atan2ba_prep #(
		.COORD_BITS (COORD_BITS)
	) u_prep (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (take),
		.ref_axis     (ref_axis),
		.quarter_axis (quarter_axis),
		.out_valid    (valid_s[0]),
		.out_stage    (data_s[0])
	);

	for (genvar g = 0; g < atan2ba_pkg::STEPS; g++) begin : g_cordic
		atan2ba_cordic_stage #(
			.STEP (g)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_s[g]),
			.in_stage  (data_s[g]),
			.out_valid (valid_s[g+1]),
			.out_stage (data_s[g+1])
		);
	end

	atan2ba_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s[atan2ba_pkg::STEPS]),
		.in_stage (data_s[atan2ba_pkg::STEPS]),
		.done     (done),
		.angle    (angle)
	);

endmodule
